// ===== hdl/ieb_pkg.sv =====
package ieb_pkg;

   // Request action codes
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_WAIT_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD_TICKS = 2'd2;

   // Register reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RESET    = 7'd80;
   localparam logic [7:0]  ACK_WAIT_LIMIT_RESET    = 8'd250;
   localparam logic [15:0] HALF_PERIOD_TICKS_RESET = 16'd50;

   // Byte stages of a transaction
   localparam logic [1:0] STAGE_DEVICE = 2'd0;
   localparam logic [1:0] STAGE_WORD   = 2'd1;
   localparam logic [1:0] STAGE_DATA   = 2'd2;
   localparam logic [1:0] STAGE_READ   = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] word_address;
      logic [7:0] write_data;
      logic       sda_in;
   } ieb_req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } ieb_rsp_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  ack_wait_limit;
      logic [15:0] half_period_ticks;
   } ieb_cfg_type;

endpackage

// ===== hdl/ieb_seq.sv =====
module ieb_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ieb_pkg::ieb_cfg_type cfg,
   input  ieb_pkg::ieb_req_type req,
   output ieb_pkg::ieb_rsp_type rsp
);
   import ieb_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_SETUP, PH_START_HOLD, PH_TX_LOW, PH_TX_HIGH,
      PH_ACK_LOW, PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW,
      PH_NACK_HIGH, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_REL, PH_RESTART_LOW
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] div_ff, div_in;
   logic [7:0]  ack_cnt_ff, ack_cnt_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  word_ff, word_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  last_read_ff, last_read_in;
   logic        nack_ff, nack_in;
   logic [1:0]  stage_ff, stage_in;

   logic [15:0] hp;
   logic [7:0]  lim;
   logic        half_end;
   logic [7:0]  ack_cnt_inc;
   logic [3:0]  bit_count_inc;
   logic [7:0]  rx_byte;
   logic        after_ack;

   // Treat zero settings as one
   assign hp  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
   assign lim = (cfg.ack_wait_limit == 8'd0) ? 8'd1 : cfg.ack_wait_limit;
   assign half_end      = ({1'b0, div_ff} + 17'd1) >= {1'b0, hp};
   assign ack_cnt_inc   = ack_cnt_ff + 8'd1;
   assign bit_count_inc = bit_count_ff + 4'd1;
   assign rx_byte       = {shift_ff[6:0], req.sda_in};

   // Drive bus levels and status from the current phase
   always_comb begin
      rsp.scl_out     = 1'b1;
      rsp.sda_out     = 1'b1;
      rsp.busy_res    = 1'b1;
      rsp.done_res    = 1'b0;
      rsp.read_data   = last_read_ff;
      rsp.ack_missing = nack_ff;
      case (phase_ff)
         PH_IDLE:        rsp.busy_res = 1'b0;
         PH_START_SETUP: ;
         PH_START_HOLD:  rsp.sda_out = 1'b0;
         PH_TX_LOW: begin
            rsp.scl_out = 1'b0;
            rsp.sda_out = shift_ff[7];
         end
         PH_TX_HIGH:     rsp.sda_out = shift_ff[7];
         PH_ACK_LOW:     rsp.scl_out = 1'b0;
         PH_ACK_HIGH:    ;
         PH_RX_LOW:      rsp.scl_out = 1'b0;
         PH_RX_HIGH:     ;
         PH_NACK_LOW:    rsp.scl_out = 1'b0;
         PH_NACK_HIGH:   ;
         PH_STOP_LOW: begin
            rsp.scl_out = 1'b0;
            rsp.sda_out = 1'b0;
         end
         PH_STOP_HIGH:   rsp.sda_out = 1'b0;
         PH_STOP_REL:    rsp.done_res = half_end;
         PH_RESTART_LOW: rsp.scl_out = 1'b0;
         default:        rsp.scl_out = 1'b0;
      endcase
   end

   // Advance the bus sequencer by one tick
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      div_in       = div_ff;
      ack_cnt_in   = ack_cnt_ff;
      is_read_in   = is_read_ff;
      word_in      = word_ff;
      data_in      = data_ff;
      last_read_in = last_read_ff;
      nack_in      = nack_ff;
      stage_in     = stage_ff;
      after_ack    = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req.action == ACT_WRITE || req.action == ACT_READ) begin
                  is_read_in = (req.action == ACT_READ);
                  word_in    = req.word_address;
                  data_in    = req.write_data;
                  nack_in    = 1'b0;
                  stage_in   = STAGE_DEVICE;
                  phase_in   = PH_START_SETUP;
                  div_in     = 16'd0;
               end
            end
            PH_ACK_HIGH: begin
               if (!req.sda_in) begin
                  after_ack = 1'b1;
               end else begin
                  ack_cnt_in = ack_cnt_inc;
                  if (ack_cnt_inc >= lim || ack_cnt_inc == 8'd0) begin
                     nack_in   = 1'b1;
                     after_ack = 1'b1;
                  end
               end
            end
            default: begin
               if (!half_end) begin
                  div_in = div_ff + 16'd1;
               end else begin
                  div_in = 16'd0;
                  case (phase_ff)
                     PH_START_SETUP: phase_in = PH_START_HOLD;
                     PH_START_HOLD: begin
                        shift_in     = {cfg.device_address, (stage_ff == STAGE_READ)};
                        bit_count_in = 4'd0;
                        phase_in     = PH_TX_LOW;
                     end
                     PH_TX_LOW: phase_in = PH_TX_HIGH;
                     PH_TX_HIGH: begin
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_count_in = bit_count_inc;
                        phase_in     = (bit_count_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                     end
                     PH_ACK_LOW: begin
                        ack_cnt_in = 8'd0;
                        phase_in   = PH_ACK_HIGH;
                     end
                     PH_RX_LOW: phase_in = PH_RX_HIGH;
                     PH_RX_HIGH: begin
                        shift_in     = rx_byte;
                        bit_count_in = bit_count_inc;
                        if (bit_count_inc >= 4'd8) begin
                           last_read_in = rx_byte;
                           phase_in     = PH_NACK_LOW;
                        end else begin
                           phase_in = PH_RX_LOW;
                        end
                     end
                     PH_NACK_LOW:    phase_in = PH_NACK_HIGH;
                     PH_NACK_HIGH:   phase_in = PH_STOP_LOW;
                     PH_STOP_LOW:    phase_in = PH_STOP_HIGH;
                     PH_STOP_HIGH:   phase_in = PH_STOP_REL;
                     PH_STOP_REL:    phase_in = PH_IDLE;
                     PH_RESTART_LOW: phase_in = PH_START_SETUP;
                     default:        phase_in = PH_IDLE;
                  endcase
               end
            end
         endcase

         // Pick the next byte once an acknowledge slot closes
         if (after_ack) begin
            div_in = 16'd0;
            case (stage_ff)
               STAGE_DEVICE: begin
                  stage_in     = STAGE_WORD;
                  shift_in     = word_ff;
                  bit_count_in = 4'd0;
                  phase_in     = PH_TX_LOW;
               end
               STAGE_WORD: begin
                  if (is_read_ff) begin
                     stage_in = STAGE_READ;
                     phase_in = PH_RESTART_LOW;
                  end else begin
                     stage_in     = STAGE_DATA;
                     shift_in     = data_ff;
                     bit_count_in = 4'd0;
                     phase_in     = PH_TX_LOW;
                  end
               end
               STAGE_DATA: phase_in = PH_STOP_LOW;
               default: begin
                  shift_in     = 8'd0;
                  bit_count_in = 4'd0;
                  phase_in     = PH_RX_LOW;
               end
            endcase
         end
      end
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         div_ff       <= 16'd0;
         ack_cnt_ff   <= 8'd0;
         is_read_ff   <= 1'b0;
         word_ff      <= 8'd0;
         data_ff      <= 8'd0;
         last_read_ff <= 8'd0;
         nack_ff      <= 1'b0;
         stage_ff     <= STAGE_DEVICE;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         div_ff       <= div_in;
         ack_cnt_ff   <= ack_cnt_in;
         is_read_ff   <= is_read_in;
         word_ff      <= word_in;
         data_ff      <= data_in;
         last_read_ff <= last_read_in;
         nack_ff      <= nack_in;
         stage_ff     <= stage_in;
      end
   end

endmodule

// ===== hdl/i2c_eeprom_byte_master_core.sv =====
// I2C master for a serial EEPROM: byte write and random single-byte read.
// req channel: one item per bus tick, carrying an optional request (action,
// word_address, write_data) and the sampled SDA level. Requests are taken
// only while no transaction is in flight; others are dropped.
// rsp channel: exactly one item per req item, giving the SCL and SDA drive,
// busy, the done pulse at the end of stop, the last read byte and the
// acknowledge timeout flag, all as they stood before that tick's update.
// csr channel: writes device_address (0), ack_wait_limit (1) and
// half_period_ticks (2); always ready, write only while idle.
// An accepted item passes from the input register to the result register,
// where it shows on rsp. Throughput: one item per cycle while rsp is not
// stalled, set by the single sequencer update between the two registers.
// A stalled rsp holds its item; req keeps being taken while the input
// register can move forward into the result register.
// Reset (synchronous): sequencer idle, registers at 80, 250 and 50,
// both channel registers empty.
module i2c_eeprom_byte_master_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  ieb_pkg::ieb_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ieb_pkg::ieb_rsp_type                   rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ieb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ieb_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import ieb_pkg::*;

   ieb_req_type req_ff, req_in;
   logic        req_vld_ff, req_vld_in;
   ieb_rsp_type rsp_ff, rsp_in;
   logic        rsp_vld_ff, rsp_vld_in;
   ieb_cfg_type cfg_ff, cfg_in;
   ieb_rsp_type seq_rsp;
   logic        advance;

   // Move the held item into the result register when it has room
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   ieb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cfg   (cfg_ff),
      .req   (req_ff),
      .rsp   (seq_rsp)
   );

   // Next values of channel and config registers
   always_comb begin
      req_in     = req_ff;
      req_vld_in = req_vld_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      cfg_in     = cfg_ff;
      if (req_valid && req_ready) begin
         req_in     = req_data;
         req_vld_in = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end
      if (advance) begin
         rsp_in     = seq_rsp;
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:    cfg_in.device_address    = csr_data[6:0];
            CSR_ACK_WAIT_LIMIT:    cfg_in.ack_wait_limit    = csr_data[7:0];
            CSR_HALF_PERIOD_TICKS: cfg_in.half_period_ticks = csr_data;
            default:               ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_vld_ff               <= 1'b0;
         rsp_vld_ff               <= 1'b0;
         cfg_ff.device_address    <= DEVICE_ADDRESS_RESET;
         cfg_ff.ack_wait_limit    <= ACK_WAIT_LIMIT_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_TICKS_RESET;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         cfg_ff     <= cfg_in;
      end
   end

endmodule

// ===== hdl/ieb_checker.sv =====
module ieb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input ieb_pkg::ieb_req_type                req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input ieb_pkg::ieb_rsp_type                rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [ieb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [ieb_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ieb_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed or dropped");

   // Never block req while the result side drains
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp is ready");

   // Done only during a transaction
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   // Release the bus when idle
   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.scl_out && rsp_data.sda_out)
      else $error("bus driven while idle");

endmodule

bind i2c_eeprom_byte_master_core ieb_checker u_ieb_checker (.*);

// ===== tb/sv/tb_i2c_eeprom_byte_master_core.sv =====
module tb_i2c_eeprom_byte_master_core;
   import ieb_pkg::*;

   // Bus sequencer phases, in the order the block declares them
   typedef enum logic [4:0] {
      BUS_IDLE = 5'd0,
      BUS_START_SETUP,
      BUS_START_HOLD,
      BUS_TX_LOW,
      BUS_TX_HIGH,
      BUS_ACK_LOW,
      BUS_ACK_HIGH,
      BUS_RX_LOW,
      BUS_RX_HIGH,
      BUS_NACK_LOW,
      BUS_NACK_HIGH,
      BUS_STOP_LOW,
      BUS_STOP_HIGH,
      BUS_STOP_REL,
      BUS_RESTART_LOW
   } bus_phase_type;

   localparam logic [1:0] ACT_RESERVED = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 2'd3;

   // Tracks the I2C sequencer tick by tick and holds the bus levels it should show
   class bus_tick_scoreboard;
      ieb_cfg_type   cfg;
      bus_phase_type phase;
      logic [3:0]    bit_cnt;
      logic [7:0]    shifter;
      logic [15:0]   div_cnt;
      logic [7:0]    ack_cnt;
      ieb_req_type   held_req;
      logic [7:0]    read_byte;
      logic          nack_seen;
      logic [1:0]    stage;
      ieb_rsp_type   expected_ticks[$];
      int unsigned   mismatches;
      int unsigned   ticks_checked;
      int unsigned   writes_started;
      int unsigned   reads_started;
      int unsigned   ack_timeouts;

      function new();
         cfg.device_address    = DEVICE_ADDRESS_RESET;
         cfg.ack_wait_limit    = ACK_WAIT_LIMIT_RESET;
         cfg.half_period_ticks = HALF_PERIOD_TICKS_RESET;
         phase     = BUS_IDLE;
         bit_cnt   = '0;
         shifter   = '0;
         div_cnt   = '0;
         ack_cnt   = '0;
         held_req  = '0;
         read_byte = '0;
         nack_seen = 1'b0;
         stage     = STAGE_DEVICE;
         mismatches     = 0;
         ticks_checked  = 0;
         writes_started = 0;
         reads_started  = 0;
         ack_timeouts   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_DEVICE_ADDRESS:    cfg.device_address    = value[6:0];
            CSR_ACK_WAIT_LIMIT:    cfg.ack_wait_limit    = value[7:0];
            CSR_HALF_PERIOD_TICKS: cfg.half_period_ticks = value;
            default: ;
         endcase
      endfunction

      function void enter_phase(bus_phase_type next);
         phase   = next;
         div_cnt = '0;
      endfunction

      function void load_byte(logic [7:0] value);
         shifter = value;
         bit_cnt = '0;
         enter_phase(BUS_TX_LOW);
      endfunction

      // Pick the next byte of the transaction once an ack slot closes
      function void advance_after_ack();
         case (stage)
            STAGE_DEVICE: begin
               stage = STAGE_WORD;
               load_byte(held_req.word_address);
            end
            STAGE_WORD: begin
               if (held_req.action == ACT_READ) begin
                  stage = STAGE_READ;
                  enter_phase(BUS_RESTART_LOW);
               end else begin
                  stage = STAGE_DATA;
                  load_byte(held_req.write_data);
               end
            end
            STAGE_DATA: enter_phase(BUS_STOP_LOW);
            default: begin
               shifter = '0;
               bit_cnt = '0;
               enter_phase(BUS_RX_LOW);
            end
         endcase
      endfunction

      // Record the bus levels for this tick, then advance the sequencer
      function void note_tick(ieb_req_type item);
         ieb_rsp_type want;
         int          hp;
         int          lim;
         bit          half_end;
         hp  = (cfg.half_period_ticks == 0) ? 1 : int'(cfg.half_period_ticks);
         lim = (cfg.ack_wait_limit == 0) ? 1 : int'(cfg.ack_wait_limit);
         half_end = (int'(div_cnt) + 1 >= hp);

         want.scl_out  = 1'b1;
         want.sda_out  = 1'b1;
         want.busy_res = 1'b1;
         want.done_res = 1'b0;
         case (phase)
            BUS_IDLE: want.busy_res = 1'b0;
            BUS_START_SETUP, BUS_ACK_HIGH, BUS_RX_HIGH, BUS_NACK_HIGH: ;
            BUS_START_HOLD: want.sda_out = 1'b0;
            BUS_TX_LOW: begin
               want.scl_out = 1'b0;
               want.sda_out = shifter[7];
            end
            BUS_TX_HIGH: want.sda_out = shifter[7];
            BUS_STOP_LOW: begin
               want.scl_out = 1'b0;
               want.sda_out = 1'b0;
            end
            BUS_STOP_HIGH: want.sda_out = 1'b0;
            BUS_STOP_REL: want.done_res = half_end;
            default: want.scl_out = 1'b0;
         endcase
         want.read_data   = read_byte;
         want.ack_missing = nack_seen;
         expected_ticks.push_back(want);

         if (phase == BUS_IDLE) begin
            // take a request only from idle
            if (item.action == ACT_WRITE || item.action == ACT_READ) begin
               held_req  = item;
               nack_seen = 1'b0;
               stage     = STAGE_DEVICE;
               enter_phase(BUS_START_SETUP);
               if (item.action == ACT_READ) reads_started++;
               else writes_started++;
            end
         end else if (phase == BUS_ACK_HIGH) begin
            // wait for the slave to pull SDA low, give up after the limit
            if (!item.sda_in) begin
               advance_after_ack();
            end else begin
               ack_cnt = ack_cnt + 8'd1;
               if (int'(ack_cnt) >= lim || ack_cnt == 0) begin
                  nack_seen = 1'b1;
                  ack_timeouts++;
                  advance_after_ack();
               end
            end
         end else if (!half_end) begin
            div_cnt = div_cnt + 16'd1;
         end else begin
            case (phase)
               BUS_START_SETUP: enter_phase(BUS_START_HOLD);
               BUS_START_HOLD:  load_byte({cfg.device_address, stage == STAGE_READ});
               BUS_TX_LOW:      enter_phase(BUS_TX_HIGH);
               BUS_TX_HIGH: begin
                  shifter = shifter << 1;
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= 4'd8) enter_phase(BUS_ACK_LOW);
                  else enter_phase(BUS_TX_LOW);
               end
               BUS_ACK_LOW: begin
                  ack_cnt = '0;
                  enter_phase(BUS_ACK_HIGH);
               end
               BUS_RX_LOW: enter_phase(BUS_RX_HIGH);
               BUS_RX_HIGH: begin
                  shifter = {shifter[6:0], item.sda_in};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= 4'd8) begin
                     read_byte = shifter;
                     enter_phase(BUS_NACK_LOW);
                  end else begin
                     enter_phase(BUS_RX_LOW);
                  end
               end
               BUS_NACK_LOW:    enter_phase(BUS_NACK_HIGH);
               BUS_NACK_HIGH:   enter_phase(BUS_STOP_LOW);
               BUS_STOP_LOW:    enter_phase(BUS_STOP_HIGH);
               BUS_STOP_HIGH:   enter_phase(BUS_STOP_REL);
               BUS_STOP_REL:    enter_phase(BUS_IDLE);
               BUS_RESTART_LOW: enter_phase(BUS_START_SETUP);
               default:         enter_phase(BUS_IDLE);
            endcase
         end
      endfunction

      function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
         if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
         end
      endfunction

      // Compare one result item against the oldest expected tick
      function void check_tick(ieb_rsp_type got);
         ieb_rsp_type want;
         if (expected_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: result item with none expected, expected nothing got %h",
                        $time, got);
            return;
         end
         want = expected_ticks.pop_front();
         ticks_checked++;
         compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
         compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   ieb_req_type                req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   ieb_rsp_type                rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   bus_tick_scoreboard board = new();
   bit          quiet;
   bit          slave_present;
   int unsigned send_gap_odds;
   int unsigned rsp_gap_odds;
   int unsigned sent_ticks;

   i2c_eeprom_byte_master_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Behave like an EEPROM on SDA: ack most slots when present, random bits elsewhere
   function automatic bit slave_sda();
      if (board.phase == BUS_ACK_HIGH) begin
         if (!slave_present) return 1'b1;
         return $urandom_range(0, 3) == 0;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   // Mostly empty ticks while busy, sometimes a request that must be dropped
   function automatic logic [1:0] busy_action();
      if ($urandom_range(0, 3) != 0) return ACT_NONE;
      return 2'($urandom_range(0, 3));
   endfunction

   function automatic int unsigned pick_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 12;
      endcase
   endfunction

   // Offer one tick item and hold it until taken
   task automatic send_tick(input logic [1:0] action, input logic [7:0] word,
                            input logic [7:0] data);
      ieb_req_type item;
      item.action       = action;
      item.word_address = word;
      item.write_data   = data;
      item.sda_in       = slave_sda();
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_tick(item);
      sent_ticks++;
      if (!quiet && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_ticks.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      while (board.phase != BUS_IDLE) send_tick(busy_action(), 8'($urandom), 8'($urandom));
      drain();
   endtask

   // Issue one request and clock the bus until the sequencer is idle again
   task automatic run_transfer(input logic [1:0] action, input logic [7:0] word,
                               input logic [7:0] data);
      send_tick(action, word, data);
      while (board.phase != BUS_IDLE) begin
         if (!quiet && $urandom_range(0, 299) == 0) drain();
         send_tick(busy_action(), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   // Reprogram all registers from idle
   task automatic configure(input logic [15:0] dev, input logic [15:0] ack,
                            input logic [15:0] hp, input bit touch_spare);
      settle();
      write_register(CSR_DEVICE_ADDRESS, dev);
      write_register(CSR_ACK_WAIT_LIMIT, ack);
      write_register(CSR_HALF_PERIOD_TICKS, hp);
      if (touch_spare) write_register(CSR_SPARE_INDEX, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Result side: check every taken item, stall in random bursts
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_tick(rsp_data);
         if (reset || quiet || rsp_gap_odds == 0) begin
            rsp_ready <= !reset;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(1, rsp_gap_odds) == 1) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned random_start;
      logic [1:0]  kind;
      logic [15:0] ack_pick;
      logic [15:0] hp_pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      quiet         = 1'b0;
      slave_present = 1'b1;
      send_gap_odds = 6;
      rsp_gap_odds  = 6;
      sent_ticks    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset address and ack limit with a short half period: one byte write
      // with extreme address and data
      write_register(CSR_HALF_PERIOD_TICKS, 16'd2);
      csr_valid <= 1'b0;
      run_transfer(ACT_WRITE, 8'h00, 8'hFF);

      // zero half period and zero ack limit with no slave: every ack times out
      configure(16'd0, 16'd0, 16'd0, 1'b1);
      slave_present = 1'b0;
      run_transfer(ACT_WRITE, 8'hFF, 8'h00);
      slave_present = 1'b1;

      // reserved code and empty tick at idle start nothing
      send_tick(ACT_RESERVED, 8'($urandom), 8'($urandom));
      send_tick(ACT_NONE, 8'($urandom), 8'($urandom));

      // top device address, longest ack wait, random read
      configure(16'd127, 16'd255, 16'd1, 1'b0);
      run_transfer(ACT_READ, 8'hFF, 8'hA5);
      slave_present = 1'b0;
      run_transfer(ACT_READ, 8'h5A, 8'h00);
      slave_present = 1'b1;

      // longest half period: idle ticks only
      configure(16'd80, 16'd250, 16'hFFFF, 1'b0);
      repeat (4) send_tick(ACT_NONE, 8'($urandom), 8'($urandom));

      // random rounds: new settings, then a few transfers with random content
      random_start = sent_ticks;
      while (sent_ticks - random_start < 600) begin
         quiet = (sent_ticks - random_start >= 450);
         send_gap_odds = pick_odds();
         rsp_gap_odds  = pick_odds();
         case ($urandom_range(0, 9))
            0:       ack_pick = 16'd0;
            1:       ack_pick = 16'd255;
            default: ack_pick = 16'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       hp_pick = 16'd0;
            1:       hp_pick = 16'($urandom_range(4, 12));
            default: hp_pick = 16'($urandom_range(1, 3));
         endcase
         if (!quiet)
            configure(16'($urandom_range(0, 127)), ack_pick, hp_pick,
                      $urandom_range(0, 7) == 0);
         repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(0, 9))
               0:          kind = ACT_NONE;
               1:          kind = ACT_RESERVED;
               2, 3, 4, 5: kind = ACT_WRITE;
               default:    kind = ACT_READ;
            endcase
            slave_present = ($urandom_range(0, 7) != 0);
            run_transfer(kind, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 3)) send_tick(ACT_NONE, 8'($urandom), 8'($urandom));
         end
      end

      // drain and let the pipeline run empty
      quiet = 1'b1;
      drain();
      repeat (8) @(posedge clock);
      $display("ran %0d ticks: %0d byte writes, %0d random reads, %0d ack timeouts",
               sent_ticks, board.writes_started, board.reads_started, board.ack_timeouts);
      $display("checked %0d result items with %0d mismatches",
               board.ticks_checked, board.mismatches);
      if (board.mismatches == 0 && board.expected_ticks.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ieb_pkg.sv
hdl/ieb_seq.sv
hdl/i2c_eeprom_byte_master_core.sv
hdl/ieb_checker.sv
tb/sv/tb_i2c_eeprom_byte_master_core.sv
